// ===== rtl/thscd_pkg.sv =====
// shared types, command codes and coil table for the half-step command decoder
package thscd_pkg;

    localparam logic [7:0] CMD_PERIOD     = 8'hC0;
    localparam logic [7:0] CMD_POWER_MASK = 8'hA0;
    localparam logic [7:0] ECHO_CMD       = 8'h7F;
    localparam logic [7:0] CMD_FLAG       = 8'h80;

    localparam logic [2:0] PHASE_RESET  = 3'd0;
    localparam logic [1:0] POWER_RESET  = 2'b11;
    localparam logic [7:0] PERIOD_RESET = 8'd16;

    typedef logic [2:0] phase_t;
    typedef logic [3:0] coils_t;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic       was_step;
        coils_t     coils_x;
        coils_t     coils_y;
        coils_t     coils_z;
        logic [1:0] power_lines;
        logic [7:0] period_setting;
    } result_t;

    // half-step coil pattern for each phase
    function automatic coils_t halfstep_coils(input phase_t phase);
        coils_t coils;
        case (phase)
            3'd0:    coils = 4'h9;
            3'd1:    coils = 4'h8;
            3'd2:    coils = 4'hC;
            3'd3:    coils = 4'h4;
            3'd4:    coils = 4'h6;
            3'd5:    coils = 4'h2;
            3'd6:    coils = 4'h3;
            3'd7:    coils = 4'h1;
            default: coils = 4'h9;
        endcase
        return coils;
    endfunction

    // advance and retreat cancel when both are set
    function automatic phase_t move_phase(input phase_t phase, input logic fwd,
                                          input logic back);
        return phase + {2'b00, fwd} - {2'b00, back};
    endfunction

endpackage

// ===== rtl/thscd_if.sv =====
// valid/ready channels for host bytes and decoder results
interface thscd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] host_byte;

    modport source (output valid, output host_byte, input ready);
    modport sink   (input valid, input host_byte, output ready);
endinterface

interface thscd_out_if;
    logic                valid;
    logic                ready;
    logic [7:0]          echo_byte;
    logic                was_step;
    thscd_pkg::coils_t   coils_x;
    thscd_pkg::coils_t   coils_y;
    thscd_pkg::coils_t   coils_z;
    logic [1:0]          power_lines;
    logic [7:0]          period_setting;

    modport source (output valid, output echo_byte, output was_step, output coils_x,
                    output coils_y, output coils_z, output power_lines,
                    output period_setting, input ready);
    modport sink   (input valid, input echo_byte, input was_step, input coils_x,
                    input coils_y, input coils_z, input power_lines,
                    input period_setting, output ready);
endinterface

// ===== rtl/thscd_decode.sv =====
// decoder state registers and per-byte next-state and result logic
module thscd_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          host_byte,
    output thscd_pkg::result_t  result
);

    thscd_pkg::phase_t phase_x_reg, phase_x_next;
    thscd_pkg::phase_t phase_y_reg, phase_y_next;
    thscd_pkg::phase_t phase_z_reg, phase_z_next;
    logic              awaiting_reg, awaiting_next;
    logic [1:0]        power_reg, power_next;
    logic [7:0]        period_reg, period_next;
    logic              is_step;

    always_comb
    begin
        phase_x_next  = phase_x_reg;
        phase_y_next  = phase_y_reg;
        phase_z_next  = phase_z_reg;
        awaiting_next = awaiting_reg;
        power_next    = power_reg;
        period_next   = period_reg;
        is_step       = ((host_byte & thscd_pkg::CMD_FLAG) == 8'h00) && !awaiting_reg;

        if (is_step)
        begin
            phase_x_next = thscd_pkg::move_phase(phase_x_reg, host_byte[0], host_byte[3]);
            phase_y_next = thscd_pkg::move_phase(phase_y_reg, host_byte[1], host_byte[4]);
            phase_z_next = thscd_pkg::move_phase(phase_z_reg, host_byte[2], host_byte[5]);
        end
        else if (awaiting_reg)
        begin
            // byte after the period command is always data
            period_next   = host_byte;
            awaiting_next = 1'b0;
        end
        else
        begin
            if (host_byte == thscd_pkg::CMD_PERIOD)
            begin
                awaiting_next = 1'b1;
            end
            if ((host_byte & thscd_pkg::CMD_POWER_MASK) == thscd_pkg::CMD_POWER_MASK)
            begin
                power_next = host_byte[1:0];
            end
        end
    end

    always_comb
    begin
        result.echo_byte      = is_step ? host_byte : thscd_pkg::ECHO_CMD;
        result.was_step       = is_step;
        result.coils_x        = thscd_pkg::halfstep_coils(phase_x_next);
        result.coils_y        = thscd_pkg::halfstep_coils(phase_y_next);
        result.coils_z        = thscd_pkg::halfstep_coils(phase_z_next);
        result.power_lines    = power_next;
        result.period_setting = period_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_x_reg  <= thscd_pkg::PHASE_RESET;
            phase_y_reg  <= thscd_pkg::PHASE_RESET;
            phase_z_reg  <= thscd_pkg::PHASE_RESET;
            awaiting_reg <= 1'b0;
            power_reg    <= thscd_pkg::POWER_RESET;
            period_reg   <= thscd_pkg::PERIOD_RESET;
        end
        else if (fire)
        begin
            phase_x_reg  <= phase_x_next;
            phase_y_reg  <= phase_y_next;
            phase_z_reg  <= phase_z_next;
            awaiting_reg <= awaiting_next;
            power_reg    <= power_next;
            period_reg   <= period_next;
        end
    end

endmodule

// ===== rtl/three_axis_halfstep_command_decoder.sv =====
// Three-axis half-step command decoder. Each host byte gives exactly one result item. A byte
// is captured in an input register, decoded against the phase, power and period registers in
// one pass of logic, and the result is then written into an output register. One byte is
// accepted every cycle; the output register is taken away by the sink in the same cycle it is
// refilled, so throughput only drops when the result side stalls. Step bytes (bit 7 clear)
// move the X/Y/Z phases and are echoed; 0xC0 makes the next byte the step period; bytes
// matching 0xA0 set the two power lines. Non-step bytes echo 0x7F.
// The coil, power and period fields show state after the byte is applied.
module three_axis_halfstep_command_decoder (
    input  logic        clk,
    input  logic        rst_n,
    thscd_in_if.sink    host,
    thscd_out_if.source result
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    thscd_pkg::result_t out_reg;
    thscd_pkg::result_t decoded;
    logic               advance;

    // move the captured byte on when the result slot is free or being emptied
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign host.ready = !in_valid_reg || advance;

    thscd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .host_byte (in_byte_reg),
        .result    (decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (host.ready)
            begin
                in_valid_reg <= host.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (host.ready && host.valid)
        begin
            in_byte_reg <= host.host_byte;
        end
        if (advance)
        begin
            out_reg <= decoded;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.echo_byte      = out_reg.echo_byte;
    assign result.was_step       = out_reg.was_step;
    assign result.coils_x        = out_reg.coils_x;
    assign result.coils_y        = out_reg.coils_y;
    assign result.coils_z        = out_reg.coils_z;
    assign result.power_lines    = out_reg.power_lines;
    assign result.period_setting = out_reg.period_setting;

endmodule
